FILE: rtl/mrle_pkg.sv
// mrle_pkg: shared constants and types of the mask run-length string encoder
// no dependencies; used by the interfaces and every module of the encoder
`default_nettype none

package mrle_pkg;

  localparam int PIXEL_W     = 8;
  localparam int CHAR_W      = 7;
  localparam int GROUP_BITS  = 5;
  localparam int RUN_BITS_MAX = 29;

  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_CONT   = 7'h20;

  localparam logic [1:0] RUNS_SAT = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic last_of_item;
    logic end_of_mask;
  } mrle_flags_t;

  typedef struct packed {
    logic room2;
    logic empty;
  } mrle_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/mrle_pixel_if.sv
// mrle_pixel_if: valid/ready channel carrying one mask pixel per item
// depends on mrle_pkg
`default_nettype none

interface mrle_pixel_if;
  import mrle_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/mrle_char_if.sv
// mrle_char_if: valid/ready channel carrying one encoded character per item
// depends on mrle_pkg
`default_nettype none

interface mrle_char_if;
  import mrle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] code_char;
  logic              last_of_item;
  logic              end_of_mask;

  modport source (output valid, output code_char, output last_of_item,
                  output end_of_mask, input ready);
  modport sink   (input valid, input code_char, input last_of_item,
                  input end_of_mask, output ready);
endinterface

`default_nettype wire

FILE: rtl/mrle_front.sv
// mrle_front: accepts pixels, tracks runs and produces the run values to encode
// depends on mrle_pkg and mrle_pixel_if
`default_nettype none

module mrle_front #(
  parameter int RUN_BITS = 24,
  parameter int VAL_W    = RUN_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  mrle_pixel_if.sink            pixels,
  input  mrle_pkg::mrle_qstat_t qstat,
  output logic                  push0,
  output logic [VAL_W-1:0]      data0,
  output mrle_pkg::mrle_flags_t flags0,
  output logic                  push1,
  output logic [VAL_W-1:0]      data1,
  output mrle_pkg::mrle_flags_t flags1
);
  import mrle_pkg::*;

  logic                level;
  logic [RUN_BITS-1:0] run_length;
  logic [1:0]          runs;
  logic [RUN_BITS-1:0] prev_run;
  logic [RUN_BITS-1:0] prev2_run;

  logic                lvl;
  logic                chg;
  logic                take;
  logic [RUN_BITS-1:0] run_inc;
  logic [1:0]          runs_a;
  logic [VAL_W-1:0]    val_a;
  logic [RUN_BITS-1:0] len_b;
  logic [RUN_BITS-1:0] rbp_b;
  logic [1:0]          runs_b;
  logic [VAL_W-1:0]    val_b;

  assign pixels.ready = qstat.room2;

  always_comb begin
    lvl     = |pixels.pixel;
    chg     = lvl != level;
    take    = pixels.valid && pixels.ready;
    run_inc = (run_length == '1) ? run_length : run_length + RUN_BITS'(1);
    runs_a  = (runs == RUNS_SAT) ? RUNS_SAT : runs + 2'd1;
    val_a   = VAL_W'(run_length) - ((runs == RUNS_SAT) ? VAL_W'(prev2_run) : '0);
    len_b   = chg ? RUN_BITS'(1) : run_inc;
    rbp_b   = chg ? prev_run : prev2_run;
    runs_b  = chg ? runs_a : runs;
    val_b   = VAL_W'(len_b) - ((runs_b == RUNS_SAT) ? VAL_W'(rbp_b) : '0);

    push0  = take && (chg || pixels.last_pixel);
    data0  = chg ? val_a : val_b;
    flags0 = chg ? mrle_flags_t'{last_of_item: !pixels.last_pixel, end_of_mask: 1'b0}
                 : mrle_flags_t'{last_of_item: 1'b1, end_of_mask: 1'b1};
    push1  = take && chg && pixels.last_pixel;
    data1  = val_b;
    flags1 = mrle_flags_t'{last_of_item: 1'b1, end_of_mask: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= 1'b0;
      run_length <= '0;
      runs       <= '0;
      prev_run   <= '0;
      prev2_run  <= '0;
    end else if (take) begin
      if (pixels.last_pixel) begin
        level      <= 1'b0;
        run_length <= '0;
        runs       <= '0;
        prev_run   <= '0;
        prev2_run  <= '0;
      end else if (chg) begin
        level      <= lvl;
        run_length <= RUN_BITS'(1);
        runs       <= runs_a;
        prev2_run  <= prev_run;
        prev_run   <= run_length;
      end else begin
        run_length <= run_inc;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrle_queue.sv
// mrle_queue: four-entry queue of run values, up to two pushes and one pop a cycle
// depends on mrle_pkg
`default_nettype none

module mrle_queue #(
  parameter int WIDTH = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push0,
  input  logic [WIDTH-1:0]      data0,
  input  mrle_pkg::mrle_flags_t flags0,
  input  logic                  push1,
  input  logic [WIDTH-1:0]      data1,
  input  mrle_pkg::mrle_flags_t flags1,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rd_data,
  output mrle_pkg::mrle_flags_t rd_flags,
  output mrle_pkg::mrle_qstat_t qstat
);
  import mrle_pkg::*;

  logic [WIDTH-1:0] data_mem [QUEUE_DEPTH];
  mrle_flags_t      flag_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  always_comb begin
    count_next  = count + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    qstat.room2 = count <= QCNT_W'(QUEUE_DEPTH - 2);
    qstat.empty = count == '0;
    rd_data     = data_mem[rptr];
    rd_flags    = flag_mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      data_mem[wptr] <= data0;
      flag_mem[wptr] <= flags0;
    end
    if (push1) begin
      data_mem[wptr + QPTR_W'(1)] <= data1;
      flag_mem[wptr + QPTR_W'(1)] <= flags1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push0) + QPTR_W'(push1);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrle_back.sv
// mrle_back: splits run values into 5-bit groups and drives the character channel
// depends on mrle_pkg and mrle_char_if
`default_nettype none

module mrle_back #(
  parameter int VAL_W = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VAL_W-1:0]      rd_data,
  input  mrle_pkg::mrle_flags_t rd_flags,
  input  mrle_pkg::mrle_qstat_t qstat,
  output logic                  pop,
  mrle_char_if.source           chars
);
  import mrle_pkg::*;

  logic                    busy;
  logic signed [VAL_W-1:0] val;
  mrle_flags_t             vflags;

  logic [GROUP_BITS-1:0]   grp;
  logic signed [VAL_W-1:0] vshift;
  logic                    more;
  logic                    emit;
  logic [CHAR_W-1:0]       ch;

  always_comb begin
    grp    = val[GROUP_BITS-1:0];
    vshift = val >>> GROUP_BITS;
    more   = grp[GROUP_BITS-1] ? (vshift != '1) : (vshift != '0);
    ch     = CHAR_W'(grp) + (more ? CHAR_CONT : '0) + CHAR_OFFSET;
    emit   = busy && (!chars.valid || chars.ready);
    pop    = !busy && !qstat.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      chars.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy   <= 1'b1;
        val    <= signed'(rd_data);
        vflags <= rd_flags;
      end else if (emit) begin
        val <= vshift;
        if (!more) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        chars.valid        <= 1'b1;
        chars.code_char    <= ch;
        chars.last_of_item <= !more && vflags.last_of_item;
        chars.end_of_mask  <= !more && vflags.end_of_mask;
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mask_rle_string_encoder_core.sv
// mask_rle_string_encoder_core: top level of the mask run-length string encoder
// depends on mrle_pkg, mrle_pixel_if, mrle_char_if, mrle_front, mrle_queue, mrle_back
// A pixel is taken in every cycle while the four-entry run queue has two free
// entries; pixels that end no run produce nothing. Each finished run becomes one
// to six characters (runs saturate at 2^min(COUNT_BITS,29)-1), so a pixel that
// finishes two runs gives up to twelve. The back end loads a run value from the
// queue into its register and then sends one character per cycle while the
// character channel takes them, so a run's first character passes the queue and
// that register, and the character rate, not the pixel rate, sets throughput on
// short runs. The first run counts background and may be zero, from the fourth
// run on the difference to the run two back is sent, and state returns to reset
// after the pixel flagged last_pixel. end_of_mask marks the final character.
`default_nettype none

module mask_rle_string_encoder_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  mrle_pixel_if.sink  pixels,
  mrle_char_if.source chars
);
  import mrle_pkg::*;

  localparam int RUN_BITS = (COUNT_BITS < RUN_BITS_MAX) ? COUNT_BITS : RUN_BITS_MAX;
  localparam int VAL_W    = RUN_BITS + 1;

  mrle_qstat_t      qstat;
  logic             push0;
  logic [VAL_W-1:0] data0;
  mrle_flags_t      flags0;
  logic             push1;
  logic [VAL_W-1:0] data1;
  mrle_flags_t      flags1;
  logic             pop;
  logic [VAL_W-1:0] rd_data;
  mrle_flags_t      rd_flags;

  mrle_front #(.RUN_BITS(RUN_BITS), .VAL_W(VAL_W)) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .qstat  (qstat),
    .push0  (push0),
    .data0  (data0),
    .flags0 (flags0),
    .push1  (push1),
    .data1  (data1),
    .flags1 (flags1)
  );

  mrle_queue #(.WIDTH(VAL_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push0    (push0),
    .data0    (data0),
    .flags0   (flags0),
    .push1    (push1),
    .data1    (data1),
    .flags1   (flags1),
    .pop      (pop),
    .rd_data  (rd_data),
    .rd_flags (rd_flags),
    .qstat    (qstat)
  );

  mrle_back #(.VAL_W(VAL_W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_data  (rd_data),
    .rd_flags (rd_flags),
    .qstat    (qstat),
    .pop      (pop),
    .chars    (chars)
  );

  // a final pixel always leaves at least one run value queued
  a_last_queues: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready && pixels.last_pixel) |=> !qstat.empty)
    else $error("final pixel left no run in the queue");

  // second push only together with the first
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0)
    else $error("second run pushed without the first");

  // the closing character of the mask also closes its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.end_of_mask) |-> chars.last_of_item)
    else $error("end of mask without last of item");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty run queue");

endmodule

`default_nettype wire
